[design/assert_macros.svh]
// Assertion macros for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: cond");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

`endif

[design/ntlv_pkg.sv]
// Constants and phase codes for the NDEF TLV record parser
package ntlv_pkg;

  localparam logic [7:0] PAYLOAD_LIMIT = 8'd32;
  localparam logic [7:0] BUF_LEN_RESET = 8'd32;

  localparam logic [7:0] TLV_NULL = 8'h00;
  localparam logic [7:0] TLV_NDEF = 8'h03;
  localparam logic [7:0] TLV_TERM = 8'hFE;

  localparam int FLAG_SR_BIT = 4;
  localparam int FLAG_IL_BIT = 3;

  localparam logic [3:0] PH_TLV_TYPE  = 4'd0;
  localparam logic [3:0] PH_OTHER_LEN = 4'd1;
  localparam logic [3:0] PH_SKIP      = 4'd2;
  localparam logic [3:0] PH_NDEF_LEN  = 4'd3;
  localparam logic [3:0] PH_FLAGS     = 4'd4;
  localparam logic [3:0] PH_TYPE_LEN  = 4'd5;
  localparam logic [3:0] PH_PAY_LEN   = 4'd6;
  localparam logic [3:0] PH_ID_LEN    = 4'd7;
  localparam logic [3:0] PH_ID_SKIP   = 4'd8;
  localparam logic [3:0] PH_TYPE      = 4'd9;
  localparam logic [3:0] PH_PAYLOAD   = 4'd10;
  localparam logic [3:0] PH_DONE      = 4'd11;

  localparam logic [1:0] OC_PENDING = 2'd0;
  localparam logic [1:0] OC_FOUND   = 2'd1;
  localparam logic [1:0] OC_FAILED  = 2'd2;

endpackage

[design/ndef_tlv_record_parser.sv]
// NDEF TLV record parser: tag buffer bytes in, payload bytes and verdict out
// Path from input accept to result: input register, then result register.
// One byte per cycle unless the output stalls; parse state updates once per byte.
// Bytes that produce no result leave nothing on the output channel.
// Reset (rst_n low, synchronous): buffer length 32, parse state cleared,
// both channel registers empty.
`include "assert_macros.svh"

module ndef_tlv_record_parser
  import ntlv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // buffer_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // [7:0] payload_byte, [15:8] type_byte,
                                     // [23:16] payload_length
  output logic        out_tlast,     // buffer_done
  output logic [1:0]  out_tuser      // [0] payload_valid, [1] found
);

  logic [7:0] buf_len_r;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       advance;

  logic [7:0] pos_r,   pos_nxt;
  logic [3:0] phase_r, phase_nxt;
  logic [7:0] rem_r,   rem_nxt;
  logic       sr_r,    sr_nxt;
  logic       il_r,    il_nxt;
  logic [7:0] tlen_r,  tlen_nxt;
  logic [7:0] plen_r,  plen_nxt;
  logic [7:0] rtype_r, rtype_nxt;
  logic [1:0] oc_r,    oc_nxt;

  logic       out_v_r;
  logic       o_pv_r, o_done_r, o_fnd_r;
  logic [7:0] o_pbyte_r, o_rtype_r, o_plen_r;

  logic [7:0] limit;
  logic [8:0] next_pos;
  logic       final_byte;
  logic [7:0] pay_len_c;
  logic [9:0] pay_end;
  logic       pay_fail;
  logic       res_pv, res_done, res_fnd;
  logic [7:0] res_rtype, res_plen;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len_r <= BUF_LEN_RESET;
    end else if (cfg_wr_en) begin
      buf_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  assign limit      = (buf_len_r == 8'd0) ? 8'd1 : buf_len_r;
  assign next_pos   = {1'b0, pos_r} + 9'd1;
  assign final_byte = next_pos >= {1'b0, limit};
  assign pay_len_c  = (phase_r == PH_PAY_LEN) ? in_byte_r : plen_r;
  assign pay_end    = {1'b0, next_pos} + {2'b00, pay_len_c};
  assign pay_fail   = (pay_len_c > PAYLOAD_LIMIT) || (pay_end > {2'b00, limit});

  always_comb begin
    logic go_type;
    logic go_pay;
    go_type   = 1'b0;
    go_pay    = 1'b0;
    pos_nxt   = next_pos[7:0];
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    sr_nxt    = sr_r;
    il_nxt    = il_r;
    tlen_nxt  = tlen_r;
    plen_nxt  = plen_r;
    rtype_nxt = rtype_r;
    oc_nxt    = oc_r;
    res_pv    = 1'b0;
    res_done  = 1'b0;
    res_fnd   = 1'b0;
    res_rtype = 8'd0;
    res_plen  = 8'd0;

    unique case (phase_r)
      PH_TLV_TYPE: begin
        if (in_byte_r == TLV_TERM) begin
          oc_nxt    = OC_FAILED;
          phase_nxt = PH_DONE;
        end else if (in_byte_r == TLV_NDEF) begin
          phase_nxt = PH_NDEF_LEN;
        end else if (in_byte_r != TLV_NULL) begin
          phase_nxt = PH_OTHER_LEN;
        end
      end
      PH_OTHER_LEN: begin
        rem_nxt   = in_byte_r;
        phase_nxt = (in_byte_r != 8'd0) ? PH_SKIP : PH_TLV_TYPE;
      end
      PH_SKIP: begin
        rem_nxt = rem_r - 8'd1;
        if (rem_nxt == 8'd0) phase_nxt = PH_TLV_TYPE;
      end
      PH_NDEF_LEN: begin
        phase_nxt = PH_FLAGS;
      end
      PH_FLAGS: begin
        sr_nxt    = in_byte_r[FLAG_SR_BIT];
        il_nxt    = in_byte_r[FLAG_IL_BIT];
        rem_nxt   = in_byte_r[FLAG_SR_BIT] ? 8'd1 : 8'd4;
        phase_nxt = PH_TYPE_LEN;
      end
      PH_TYPE_LEN: begin
        tlen_nxt  = in_byte_r;
        phase_nxt = PH_PAY_LEN;
      end
      PH_PAY_LEN: begin
        if (rem_r <= 8'd1) begin
          plen_nxt = in_byte_r;
          rem_nxt  = 8'd0;
          if (il_r) phase_nxt = PH_ID_LEN;
          else      go_type   = 1'b1;
        end else begin
          rem_nxt = rem_r - 8'd1;
        end
      end
      PH_ID_LEN: begin
        rem_nxt = in_byte_r;
        if (in_byte_r == 8'd0) go_type   = 1'b1;
        else                   phase_nxt = PH_ID_SKIP;
      end
      PH_ID_SKIP: begin
        rem_nxt = rem_r - 8'd1;
        if (rem_nxt == 8'd0) go_type = 1'b1;
      end
      PH_TYPE: begin
        if (rem_r == tlen_r) rtype_nxt = in_byte_r;
        rem_nxt = rem_r - 8'd1;
        if (rem_nxt == 8'd0) go_pay = 1'b1;
      end
      PH_PAYLOAD: begin
        res_pv  = 1'b1;
        rem_nxt = rem_r - 8'd1;
        if (rem_nxt == 8'd0) begin
          oc_nxt    = OC_FOUND;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (go_type) begin
      if (tlen_r == 8'd0) begin
        rtype_nxt = 8'd0;
        go_pay    = 1'b1;
      end else begin
        phase_nxt = PH_TYPE;
        rem_nxt   = tlen_r;
      end
    end

    if (go_pay) begin
      if (pay_fail) begin
        oc_nxt    = OC_FAILED;
        phase_nxt = PH_DONE;
      end else if (pay_len_c == 8'd0) begin
        oc_nxt    = OC_FOUND;
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_PAYLOAD;
        rem_nxt   = pay_len_c;
      end
    end

    if (final_byte) begin
      res_done = 1'b1;
      if (oc_nxt == OC_FOUND) begin
        res_fnd   = 1'b1;
        res_rtype = rtype_nxt;
        res_plen  = plen_nxt;
      end else if (phase_nxt == PH_PAYLOAD && plen_nxt >= rem_nxt) begin
        res_plen = plen_nxt - rem_nxt;
      end
      pos_nxt   = 8'd0;
      phase_nxt = PH_TLV_TYPE;
      rem_nxt   = 8'd0;
      sr_nxt    = 1'b0;
      il_nxt    = 1'b0;
      tlen_nxt  = 8'd0;
      plen_nxt  = 8'd0;
      rtype_nxt = 8'd0;
      oc_nxt    = OC_PENDING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 8'd0;
      phase_r <= PH_TLV_TYPE;
      rem_r   <= 8'd0;
      sr_r    <= 1'b0;
      il_r    <= 1'b0;
      tlen_r  <= 8'd0;
      plen_r  <= 8'd0;
      rtype_r <= 8'd0;
      oc_r    <= OC_PENDING;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      sr_r    <= sr_nxt;
      il_r    <= il_nxt;
      tlen_r  <= tlen_nxt;
      plen_r  <= plen_nxt;
      rtype_r <= rtype_nxt;
      oc_r    <= oc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= res_pv || res_done;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (res_pv || res_done)) begin
      o_pv_r    <= res_pv;
      o_pbyte_r <= res_pv ? in_byte_r : 8'd0;
      o_done_r  <= res_done;
      o_fnd_r   <= res_fnd;
      o_rtype_r <= res_rtype;
      o_plen_r  <= res_plen;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {o_plen_r, o_rtype_r, o_pbyte_r};
  assign out_tlast  = o_done_r;
  assign out_tuser  = {o_fnd_r, o_pv_r};

  // found only on final byte; lengths within limit; rem nonzero in payload
  `ASSERT_IMPL(a_found_on_last, clk, rst_n, out_v_r && o_fnd_r, o_done_r)
  `ASSERT_IMPL(a_found_len_ok, clk, rst_n, out_v_r && o_fnd_r, o_plen_r <= PAYLOAD_LIMIT)
  `ASSERT_IMPL(a_payload_rem_nz, clk, rst_n, phase_r == PH_PAYLOAD, rem_r != 8'd0)
  `ASSERT_IMPL(a_payload_in_limit, clk, rst_n, phase_r == PH_PAYLOAD, plen_r <= PAYLOAD_LIMIT)

endmodule

[dv/tb_ndef_tlv_record_parser.sv]
// Self-checking testbench: tag buffer byte streams against an in-bench parse model
module tb_ndef_tlv_record_parser;
  import ntlv_pkg::*;

  localparam int ITEM_TARGET    = 1550;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 6;

  typedef struct packed {
    logic       pay_valid;
    logic [7:0] pay_byte;
    logic       done;
    logic       found;
    logic [7:0] rec_type;
    logic [7:0] pay_len;
  } emit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  ndef_tlv_record_parser u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] tag_bytes[$];
  emit_t      pending_emits[$];

  bit in_busy = 1'b0;
  bit calm = 1'b0;
  bit idle_on = 1'b1;
  int in_gap = 0;
  int out_gap = 0;
  int quiet = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int buffers_closed = 0;
  int records_found = 0;

  // parse model state
  logic [7:0] buf_len = BUF_LEN_RESET;
  logic [7:0] pos;
  logic [3:0] phase;
  logic [8:0] left;
  logic       sr_flag;
  logic       il_flag;
  logic [7:0] tl_held;
  logic [7:0] pl_held;
  logic [7:0] rt_held;
  logic [1:0] outcome;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void restart_parse();
    pos = '0;
    phase = PH_TLV_TYPE;
    left = '0;
    sr_flag = 1'b0;
    il_flag = 1'b0;
    tl_held = '0;
    pl_held = '0;
    rt_held = '0;
    outcome = OC_PENDING;
  endfunction

  function automatic void abort_record();
    outcome = OC_FAILED;
    phase = PH_DONE;
  endfunction

  // payload accepted only if within limit and it fits before the buffer ends
  function automatic void open_payload(input int nxt, input int lim);
    if (pl_held > PAYLOAD_LIMIT || nxt + int'(pl_held) > lim) begin
      abort_record();
    end else if (pl_held == 0) begin
      outcome = OC_FOUND;
      phase = PH_DONE;
    end else begin
      phase = PH_PAYLOAD;
      left = {1'b0, pl_held};
    end
  endfunction

  function automatic void open_type(input int nxt, input int lim);
    if (tl_held == 0) begin
      rt_held = '0;
      open_payload(nxt, lim);
    end else begin
      phase = PH_TYPE;
      left = {1'b0, tl_held};
    end
  endfunction

  function automatic void parse_tag_byte(input logic [7:0] b);
    int    lim;
    int    nxt;
    emit_t e;
    lim = (buf_len == 0) ? 1 : int'(buf_len);
    nxt = int'(pos) + 1;
    e = '0;
    case (phase)
      PH_TLV_TYPE: begin
        if (b == TLV_TERM) abort_record();
        else if (b == TLV_NDEF) phase = PH_NDEF_LEN;
        else if (b != TLV_NULL) phase = PH_OTHER_LEN;
      end
      PH_OTHER_LEN: begin
        left = {1'b0, b};
        phase = (b != 0) ? PH_SKIP : PH_TLV_TYPE;
      end
      PH_SKIP: begin
        left = left - 9'd1;
        if (left == 0) phase = PH_TLV_TYPE;
      end
      PH_NDEF_LEN: phase = PH_FLAGS;
      PH_FLAGS: begin
        sr_flag = b[FLAG_SR_BIT];
        il_flag = b[FLAG_IL_BIT];
        left = sr_flag ? 9'd1 : 9'd4;
        phase = PH_TYPE_LEN;
      end
      PH_TYPE_LEN: begin
        tl_held = b;
        phase = PH_PAY_LEN;
      end
      PH_PAY_LEN: begin
        if (left <= 1) begin
          pl_held = b;
          left = '0;
          if (il_flag) phase = PH_ID_LEN;
          else open_type(nxt, lim);
        end else begin
          left = left - 9'd1;
        end
      end
      PH_ID_LEN: begin
        left = {1'b0, b};
        if (b == 0) open_type(nxt, lim);
        else phase = PH_ID_SKIP;
      end
      PH_ID_SKIP: begin
        left = left - 9'd1;
        if (left == 0) open_type(nxt, lim);
      end
      PH_TYPE: begin
        if (left == {1'b0, tl_held}) rt_held = b;
        left = left - 9'd1;
        if (left == 0) open_payload(nxt, lim);
      end
      PH_PAYLOAD: begin
        e.pay_valid = 1'b1;
        e.pay_byte = b;
        left = left - 9'd1;
        if (left == 0) begin
          outcome = OC_FOUND;
          phase = PH_DONE;
        end
      end
      default: ;
    endcase
    if (nxt >= lim) begin
      e.done = 1'b1;
      if (outcome == OC_FOUND) begin
        e.found = 1'b1;
        e.rec_type = rt_held;
        e.pay_len = pl_held;
      end else if (phase == PH_PAYLOAD && {1'b0, pl_held} >= left) begin
        e.pay_len = 8'({1'b0, pl_held} - left);
      end
      restart_parse();
    end else begin
      pos = 8'(nxt);
    end
    if (e.pay_valid || e.done) pending_emits.push_back(e);
  endfunction

  // one tag buffer image: mostly a well-formed NDEF area, sometimes noise or broken
  function automatic void queue_buffer(input int len, input int keep);
    logic [7:0] img[$];
    logic [7:0] flags;
    logic [7:0] other;
    logic       sr;
    logic       idp;
    int         kind;
    int         tl;
    int         pl;
    int         il;
    int         room;
    int         i;
    kind = $urandom_range(0, 9);
    if (kind != 0) begin
      repeat ($urandom_range(0, 2)) img.push_back(TLV_NULL);
      if ($urandom_range(0, 2) == 0) begin
        do other = rand_byte();
        while (other == TLV_NULL || other == TLV_NDEF || other == TLV_TERM);
        tl = $urandom_range(0, 4);
        img.push_back(other);
        img.push_back(8'(tl));
        repeat (tl) img.push_back(rand_byte());
      end
      if (kind == 1) img.push_back(TLV_TERM);
      sr = ($urandom_range(0, 3) != 0);
      idp = 1'($urandom_range(0, 1));
      flags = rand_byte();
      flags[FLAG_SR_BIT] = sr;
      flags[FLAG_IL_BIT] = idp;
      tl = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      il = $urandom_range(0, 3);
      img.push_back(TLV_NDEF);
      img.push_back(rand_byte());
      img.push_back(flags);
      img.push_back(8'(tl));
      room = len - img.size() - (sr ? 1 : 4) - (idp ? 1 + il : 0) - tl;
      case ($urandom_range(0, 7))
        0: pl = $urandom_range(int'(PAYLOAD_LIMIT) + 1, 255);
        1: pl = room + 1;
        default: pl = $urandom_range(0, (room < 0) ? 0 : ((room > 32) ? 32 : room));
      endcase
      if (pl < 0) pl = 0;
      if (pl > 255) pl = 255;
      if (!sr) repeat (3) img.push_back(rand_byte());
      img.push_back(8'(pl));
      if (idp) begin
        img.push_back(8'(il));
        repeat (il) img.push_back(rand_byte());
      end
      repeat (tl) img.push_back(rand_byte());
      repeat (pl) img.push_back(rand_byte());
    end
    while (img.size() < len) img.push_back(rand_byte());
    for (i = 0; i < keep && i < len; i++) tag_bytes.push_back(img[i]);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  task automatic set_buffer_length(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    buf_len = v;
  endtask

  task automatic settle();
    do @(negedge clk);
    while (tag_bytes.size() != 0 || in_busy || pending_emits.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst_n && !in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && idle_on && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 14) - 1;
        in_tvalid <= 1'b0;
      end else if (tag_bytes.size() > 0) begin
        in_tdata <= tag_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_busy = 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!calm && idle_on && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor, predictor hook and watchdog
  always @(posedge clk) begin
    emit_t e;
    bit    progress;
    if (rst_n) begin
      progress = 1'b0;
      if (in_tvalid && in_tready) begin
        parse_tag_byte(in_tdata);
        in_busy = 1'b0;
        bytes_sent++;
        progress = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        progress = 1'b1;
        results_seen++;
        if (pending_emits.size() == 0) begin
          mismatches++;
          $error("result item with no prediction waiting");
        end else begin
          e = pending_emits.pop_front();
          check_field("payload_valid", e.pay_valid, out_tuser[0]);
          check_field("payload_byte", e.pay_byte, out_tdata[7:0]);
          check_field("buffer_done", e.done, out_tlast);
          check_field("found", e.found, out_tuser[1]);
          check_field("type_byte", e.rec_type, out_tdata[15:8]);
          check_field("payload_length", e.pay_len, out_tdata[23:16]);
          if (e.done) buffers_closed++;
          if (e.found) records_found++;
        end
      end
      quiet = progress ? 0 : quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("ndef_tlv_record_parser test failed");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int nbuf;
    int n;
    int phase_no;
    restart_parse();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // short directed buffers: skips, short record ending on the final byte,
    // long record with empty ID/type/payload, then one-byte buffers
    set_buffer_length(8'd12);
    tag_bytes = '{TLV_NULL, 8'h02, 8'h00, TLV_NDEF, 8'h05, 8'hD1, 8'h01, 8'h03,
                  8'h54, 8'hFF, 8'h00, 8'h01,
                  8'h01, 8'h01, 8'hAA, TLV_NDEF, 8'hFF, 8'h08, 8'h00, 8'h80,
                  8'h00, 8'h00, 8'h00, 8'h00};
    settle();
    set_buffer_length(8'd1);
    tag_bytes = '{TLV_TERM, TLV_NDEF, TLV_NULL};
    settle();

    phase_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      case (phase_no)
        0: len = 255;
        1: len = 1;
        2: len = 2;
        default: begin
          case ($urandom_range(0, 5))
            0: len = $urandom_range(1, 4);
            1: len = $urandom_range(5, 16);
            2: len = $urandom_range(17, 48);
            3: len = $urandom_range(49, 100);
            4: len = $urandom_range(101, 254);
            default: len = 255;
          endcase
        end
      endcase
      calm = (bytes_sent >= ITEM_TARGET - 250);
      idle_on = !calm && ($urandom_range(0, 3) != 0);
      set_buffer_length(8'(len));
      // finish a buffer left open by the previous setting
      n = (pos == 0) ? 0 : ((int'(pos) + 1 >= len) ? 1 : len - int'(pos));
      repeat (n) tag_bytes.push_back(rand_byte());
      nbuf = 150 / len;
      if (nbuf < 1) nbuf = 1;
      if (nbuf > 25) nbuf = 25;
      repeat (nbuf) queue_buffer(len, len);
      queue_buffer(len, $urandom_range(0, len - 1));
      settle();
      phase_no++;
    end

    $display("%0d tag bytes over %0d buffer length settings, %0d result items checked",
             bytes_sent, phase_no + 2, results_seen);
    $display("%0d buffers closed, %0d records found", buffers_closed, records_found);
    if (mismatches == 0 && pending_emits.size() == 0) begin
      $display("ndef_tlv_record_parser test passed");
    end else begin
      $display("ndef_tlv_record_parser test failed");
    end
    $finish;
  end

endmodule
